FILE: rtl/wsd_pkg.sv
package wsd_pkg;

	// WebSocket opcodes that the parser acts on
	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_DATA_MAX = 4'h7;

	// header byte fields and length codes
	localparam logic [7:0] HDR_TOP_BIT  = 8'h80;
	localparam logic [6:0] LEN_CODE_16  = 7'd126;
	localparam logic [6:0] LEN_CODE_64  = 7'd127;

	// reset value of the binary payload limit
	localparam logic [31:0] MAX_PAYLOAD_RESET = 32'h0010_0000;

	// event queue between parser and output stage
	localparam int FIFO_AW    = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	typedef enum logic [2:0] {
		EV_PAYLOAD   = 3'd0,
		EV_EMPTY_END = 3'd1,
		EV_PONG_REQ  = 3'd2,
		EV_CLOSE     = 3'd3,
		EV_OVERSIZE  = 3'd4
	} ev_kind_t;

	// one classified event, unmasking is left to the back end
	typedef struct packed {
		ev_kind_t   kind;
		logic [7:0] raw;
		logic [7:0] key;
		logic       masked;
		logic       frame_end;
		logic       final_flag;
	} ev_t;

	// queue status seen by both ends
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

FILE: rtl/wsd_front.sv
module wsd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    rx_byte,
	input  logic          cfg_valid,
	input  logic [31:0]   cfg_data,
	input  wsd_pkg::fifo_stat_t q_stat,
	output logic          push,
	output wsd_pkg::ev_t  push_ev,
	output logic          closed
);
	import wsd_pkg::*;

	typedef enum logic [1:0] {
		ST_HEADER,
		ST_PAYLOAD,
		ST_CLOSED
	} st_t;

	st_t         state_q;
	logic [3:0]  hdr_idx_q;
	logic [6:0]  len_code_q;
	logic        fin_q;
	logic [3:0]  frame_op_q;
	logic        masked_q;
	logic [31:0] mask_key_q;
	logic [63:0] pay_len_q;
	logic [63:0] bytes_q;
	logic [3:0]  msg_op_q;
	logic [31:0] max_q;

	logic        accept;
	logic [6:0]  len_code_n;
	logic        masked_n;
	logic [63:0] pay_len_n;
	logic [31:0] mask_key_n;
	logic [3:0]  ext_len;
	logic [3:0]  hdr_total;
	logic [3:0]  idx_inc;
	logic        hdr_end;
	logic [3:0]  eff_op;
	logic [63:0] bytes_inc;
	logic        last;
	logic        oversize;
	logic        ev_valid;
	ev_t         ev;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign closed   = (state_q == ST_CLOSED);

	// header field update for the current byte
	always_comb begin
		len_code_n = len_code_q;
		masked_n   = masked_q;
		pay_len_n  = pay_len_q;
		mask_key_n = mask_key_q;
		if (hdr_idx_q == 4'd1) begin
			masked_n   = (rx_byte & HDR_TOP_BIT) != 8'd0;
			len_code_n = rx_byte[6:0];
			pay_len_n  = (rx_byte[6:0] < LEN_CODE_16) ? {57'd0, rx_byte[6:0]} : 64'd0;
		end
		if (len_code_n == LEN_CODE_16) begin
			ext_len = 4'd2;
		end else if (len_code_n == LEN_CODE_64) begin
			ext_len = 4'd8;
		end else begin
			ext_len = 4'd0;
		end
		if (hdr_idx_q >= 4'd2) begin
			if (hdr_idx_q < 4'd2 + ext_len) begin
				pay_len_n = {pay_len_q[55:0], rx_byte};
			end else begin
				mask_key_n = {mask_key_q[23:0], rx_byte};
			end
		end
		hdr_total = 4'd2 + ext_len + (masked_n ? 4'd4 : 4'd0);
		idx_inc   = hdr_idx_q + 4'd1;
		hdr_end   = (hdr_idx_q != 4'd0) && (idx_inc >= hdr_total);
	end

	// payload bookkeeping
	assign eff_op    = (frame_op_q == OP_CONT) ? msg_op_q : frame_op_q;
	assign bytes_inc = bytes_q + 64'd1;
	assign last      = (bytes_inc == pay_len_q);
	assign oversize  = pay_len_q > {32'd0, max_q};

	// classify the byte into at most one event
	always_comb begin
		ev_valid      = 1'b0;
		ev.kind       = EV_PAYLOAD;
		ev.raw        = 8'd0;
		ev.key        = 8'd0;
		ev.masked     = 1'b0;
		ev.frame_end  = 1'b0;
		ev.final_flag = 1'b0;
		case (state_q)
			ST_HEADER: begin
				if (hdr_end) begin
					if (frame_op_q == OP_CLOSE) begin
						ev_valid = 1'b1;
						ev.kind  = EV_CLOSE;
					end else if (pay_len_n == 64'd0) begin
						if (eff_op == OP_BINARY) begin
							ev_valid      = 1'b1;
							ev.kind       = EV_EMPTY_END;
							ev.frame_end  = 1'b1;
							ev.final_flag = fin_q;
						end else if (eff_op == OP_PING) begin
							ev_valid = 1'b1;
							ev.kind  = EV_PONG_REQ;
						end
					end
				end
			end
			ST_PAYLOAD: begin
				if (eff_op == OP_BINARY) begin
					ev_valid = 1'b1;
					if (oversize) begin
						ev.kind = EV_OVERSIZE;
					end else begin
						ev.kind       = EV_PAYLOAD;
						ev.raw        = rx_byte;
						ev.masked     = masked_q;
						ev.frame_end  = last;
						ev.final_flag = last && fin_q;
						case (bytes_q[1:0])
							2'd0:    ev.key = mask_key_q[31:24];
							2'd1:    ev.key = mask_key_q[23:16];
							2'd2:    ev.key = mask_key_q[15:8];
							default: ev.key = mask_key_q[7:0];
						endcase
					end
				end else if (eff_op == OP_PING && last) begin
					ev_valid = 1'b1;
					ev.kind  = EV_PONG_REQ;
				end
			end
			default: ev_valid = 1'b0;
		endcase
	end

	assign push    = accept && ev_valid;
	assign push_ev = ev;

	// parser state and frame fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_HEADER;
			hdr_idx_q  <= 4'd0;
			len_code_q <= 7'd0;
			fin_q      <= 1'b0;
			frame_op_q <= OP_CONT;
			masked_q   <= 1'b0;
			mask_key_q <= 32'd0;
			pay_len_q  <= 64'd0;
			bytes_q    <= 64'd0;
			msg_op_q   <= OP_CONT;
			max_q      <= MAX_PAYLOAD_RESET;
		end else begin
			if (cfg_valid) begin
				max_q <= cfg_data;
			end
			if (accept) begin
				case (state_q)
					ST_HEADER: begin
						if (hdr_idx_q == 4'd0) begin
							fin_q      <= (rx_byte & HDR_TOP_BIT) != 8'd0;
							frame_op_q <= rx_byte[3:0];
							pay_len_q  <= 64'd0;
							hdr_idx_q  <= 4'd1;
						end else begin
							masked_q   <= masked_n;
							len_code_q <= len_code_n;
							pay_len_q  <= pay_len_n;
							mask_key_q <= mask_key_n;
							if (hdr_end) begin
								hdr_idx_q <= 4'd0;
								bytes_q   <= 64'd0;
								if (frame_op_q == OP_CLOSE) begin
									state_q <= ST_CLOSED;
								end else begin
									if (frame_op_q != OP_CONT && frame_op_q <= OP_DATA_MAX) begin
										msg_op_q <= frame_op_q;
									end
									state_q <= (pay_len_n == 64'd0) ? ST_HEADER : ST_PAYLOAD;
								end
							end else begin
								hdr_idx_q <= idx_inc;
							end
						end
					end
					ST_PAYLOAD: begin
						bytes_q <= bytes_inc;
						if (eff_op == OP_BINARY && oversize) begin
							state_q <= ST_CLOSED;
						end else if (last) begin
							state_q <= ST_HEADER;
						end
					end
					default: state_q <= ST_CLOSED;
				endcase
			end
		end
	end

endmodule

FILE: rtl/wsd_fifo.sv
module wsd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  wsd_pkg::ev_t        wdata,
	input  logic                pop,
	output wsd_pkg::ev_t        rdata,
	output wsd_pkg::fifo_stat_t stat
);
	import wsd_pkg::*;

	ev_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign stat.full  = (count_q == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (FIFO_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (FIFO_AW+1)'(1);
			end
		end
	end

endmodule

FILE: rtl/wsd_back.sv
module wsd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  wsd_pkg::ev_t        q_data,
	input  wsd_pkg::fifo_stat_t q_stat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          event_kind,
	output logic [7:0]          data_byte,
	output logic                frame_end,
	output logic                message_final
);
	import wsd_pkg::*;

	logic       valid_q;
	logic [2:0] kind_q;
	logic [7:0] data_q;
	logic       end_q;
	logic       final_q;
	logic [7:0] unmasked;

	// refill the output register when it is empty or being taken
	assign pop      = !q_stat.empty && (!valid_q || out_ready);
	assign unmasked = q_data.masked ? (q_data.raw ^ q_data.key) : q_data.raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q  <= q_data.kind;
			data_q  <= unmasked;
			end_q   <= q_data.frame_end;
			final_q <= q_data.final_flag;
		end
	end

	assign out_valid     = valid_q;
	assign event_kind    = kind_q;
	assign data_byte     = data_q;
	assign frame_end     = end_q;
	assign message_final = final_q;

endmodule

FILE: rtl/websocket_rx_deframer.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    rx_byte[7:0]
// cfg       input      cfg_valid / cfg_ready  cfg_data[31:0] (max_binary_payload)
// out       output     out_valid / out_ready  event_kind[2:0], data_byte[7:0],
//                                             frame_end, message_final
//
// One byte per cycle is accepted while the four-entry event queue has room.
// A byte's event is written to the queue at its transfer edge and moves on into
// the output register when the back end pops it; bytes without an event only
// advance the parser.
// Reset clears the parser, the queue and the output register at once.
// A stalled output fills the queue; in_ready drops only when it is full.
// After a close event bytes are still taken and dropped until reset.
module websocket_rx_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_kind,
	output logic [7:0]  data_byte,
	output logic        frame_end,
	output logic        message_final
);
	import wsd_pkg::*;

	logic       push;
	logic       pop;
	logic       closed;
	ev_t        push_ev;
	ev_t        q_data;
	fifo_stat_t q_stat;

	assign cfg_ready = 1'b1;

	// header parser and event classifier
	wsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_ev   (push_ev),
		.closed    (closed)
	);

	// event queue
	wsd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_ev),
		.pop    (pop),
		.rdata  (q_data),
		.stat   (q_stat)
	);

	// unmasking and output register
	wsd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_data        (q_data),
		.q_stat        (q_stat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_kind    (event_kind),
		.data_byte     (data_byte),
		.frame_end     (frame_end),
		.message_final (message_final)
	);

	// nothing is queued once the connection is closed
	a_closed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		closed |-> !push)
		else $error("event queued after close");

	// frame end only on payload or empty binary frame results
	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> (event_kind == EV_PAYLOAD || event_kind == EV_EMPTY_END))
		else $error("frame_end on a non-frame event");

	// message_final only with frame_end
	a_final_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_final |-> frame_end)
		else $error("message_final without frame_end");

	// non-payload events carry zero data
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != EV_PAYLOAD |-> data_byte == 8'd0)
		else $error("data on a non-payload event");

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("push into full event queue");

endmodule

FILE: tb/websocket_rx_deframer_test.sv
`timescale 1ns / 100ps

module websocket_rx_deframer_test;
	import wsd_pkg::*;

	// opcodes the package does not name
	localparam logic [3:0] OP_TEXT = 4'h1;
	localparam logic [3:0] OP_PONG = 4'hA;
	localparam logic [3:0] OP_LAST = 4'hF;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned SETTLE_CYCLES = 8;

	typedef struct {
		ev_kind_t   kind;
		logic [7:0] data;
		bit         fe;
		bit         mf;
	} deframed_event_t;

	// frame parser state, expected events and mismatch count
	class deframer_model;
		logic [31:0] limit = MAX_PAYLOAD_RESET;
		bit          in_hdr = 1'b1;
		logic [3:0]  hdr_idx = '0;
		logic [6:0]  len_code = '0;
		bit          fin = 1'b0;
		logic [3:0]  frm_op = OP_CONT;
		bit          masked = 1'b0;
		logic [31:0] key = '0;
		logic [63:0] pay_len = '0;
		logic [63:0] rcvd = '0;
		logic [3:0]  msg_op = OP_CONT;
		bit          closed = 1'b0;
		int unsigned mismatches = 0;
		deframed_event_t due_events[$];

		function void add(ev_kind_t kind, logic [7:0] data, bit fe, bit mf);
			deframed_event_t e;
			e.kind = kind;
			e.data = data;
			e.fe = fe;
			e.mf = mf;
			due_events.push_back(e);
		endfunction

		// advance the parser by one accepted byte
		function void take_byte(logic [7:0] b);
			int unsigned ext, total;
			logic [3:0]  op;
			logic [63:0] k;
			bit          last;
			logic [7:0]  d;
			if (closed)
				return;
			if (in_hdr) begin
				if (hdr_idx == 0) begin
					fin = b[7];
					frm_op = b[3:0];
					pay_len = '0;
					hdr_idx = 4'd1;
					return;
				end
				if (hdr_idx == 1) begin
					masked = b[7];
					len_code = b[6:0];
					pay_len = (len_code < LEN_CODE_16) ? 64'(len_code) : 64'd0;
				end
				ext = (len_code == LEN_CODE_16) ? 2 : (len_code == LEN_CODE_64) ? 8 : 0;
				if (hdr_idx >= 2) begin
					if (hdr_idx < 2 + ext)
						pay_len = {pay_len[55:0], b};
					else
						key = {key[23:0], b};
				end
				total = 2 + ext + (masked ? 4 : 0);
				if (int'(hdr_idx) + 1 < total) begin
					hdr_idx = hdr_idx + 4'd1;
					return;
				end
				// header complete
				in_hdr = 1'b0;
				hdr_idx = '0;
				rcvd = '0;
				if (frm_op == OP_CLOSE) begin
					closed = 1'b1;
					add(EV_CLOSE, 8'd0, 1'b0, 1'b0);
					return;
				end
				if (frm_op != OP_CONT && frm_op <= OP_DATA_MAX)
					msg_op = frm_op;
				if (pay_len == 0) begin
					op = (frm_op == OP_CONT) ? msg_op : frm_op;
					in_hdr = 1'b1;
					if (op == OP_BINARY)
						add(EV_EMPTY_END, 8'd0, 1'b1, fin);
					else if (op == OP_PING)
						add(EV_PONG_REQ, 8'd0, 1'b0, 1'b0);
				end
				return;
			end
			// payload byte
			op = (frm_op == OP_CONT) ? msg_op : frm_op;
			k = rcvd;
			rcvd = k + 64'd1;
			last = (rcvd == pay_len);
			if (last) begin
				in_hdr = 1'b1;
				hdr_idx = '0;
			end
			if (op == OP_BINARY) begin
				if (pay_len > {32'd0, limit}) begin
					closed = 1'b1;
					add(EV_OVERSIZE, 8'd0, 1'b0, 1'b0);
					return;
				end
				d = b;
				if (masked)
					d ^= key[8 * (3 - int'(k[1:0])) +: 8];
				add(EV_PAYLOAD, d, last, last && fin);
			end else if (op == OP_PING && last) begin
				add(EV_PONG_REQ, 8'd0, 1'b0, 1'b0);
			end
		endfunction

		task report(string what);
			$display("%0t mismatch: %s", $time, what);
			mismatches++;
		endtask

		// compare one output transfer with the oldest expected event
		task check_event(logic [2:0] kind, logic [7:0] data, logic fe, logic mf);
			deframed_event_t e;
			if (due_events.size() == 0) begin
				report($sformatf("unexpected event kind %0d data %02h end %b final %b",
					kind, data, fe, mf));
				return;
			end
			e = due_events.pop_front();
			if ({kind, data, fe, mf} !== {e.kind, e.data, e.fe, e.mf})
				report($sformatf("got kind %0d data %02h end %b final %b, want %0d %02h %b %b",
					kind, data, fe, mf, e.kind, e.data, e.fe, e.mf));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  event_kind;
	logic [7:0]  data_byte;
	logic        frame_end;
	logic        message_final;

	deframer_model sb;
	int unsigned   items_sent = 0;
	int unsigned   cycles = 0;
	bit            quiet = 1'b0;
	int unsigned   hold_reqs = 0;
	int unsigned   hold_seen = 0;
	int unsigned   hold_left = 0;

	websocket_rx_deframer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_kind    (event_kind),
		.data_byte     (data_byte),
		.frame_end     (frame_end),
		.message_final (message_final)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// event sink: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet || ($urandom_range(99) >= 17);
		end
	end

	// output monitor
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_event(event_kind, data_byte, frame_end, message_final);

	// one byte transfer, with a random gap ahead of it
	task send_byte(input logic [7:0] b);
		if (!quiet && $urandom_range(99) < 17) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat ($urandom_range(2)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		sb.take_byte(b);
		items_sent++;
	endtask

	// frame header: FIN/opcode, mask/length code, extended length, mask key
	task send_header(input bit fin, input logic [3:0] op, input bit mk, input int form,
			input logic [63:0] len);
		logic [6:0] code;
		logic [2:0] rsv;
		int         nb;
		code = (form == 0) ? len[6:0] : (form == 1) ? LEN_CODE_16 : LEN_CODE_64;
		nb = (form == 1) ? 2 : (form == 2) ? 8 : 0;
		rsv = 3'($urandom_range(7));
		send_byte({fin, rsv, op});
		send_byte({mk, code});
		for (int i = nb - 1; i >= 0; i--)
			send_byte(len[8 * i +: 8]);
		if (mk)
			repeat (4) send_byte(8'($urandom_range(255)));
	endtask

	// true when a frame with this opcode would carry binary payload
	function bit binary_next(logic [3:0] op);
		return (op == OP_BINARY) || (op == OP_CONT && sb.msg_op == OP_BINARY);
	endfunction

	task send_frame(input bit fin, input logic [3:0] op, input bit mk, input int form,
			input logic [63:0] len);
		send_header(fin, op, mk, form, len);
		repeat (len) send_byte(8'($urandom_range(255)));
	endtask

	// mostly well-formed frames, with odd fragment orders and non-minimal lengths
	task random_frame();
		logic [3:0]  op;
		bit          fin, mk, bin;
		int          form;
		int unsigned r, len;
		r = $urandom_range(99);
		if (r < 38)
			op = OP_BINARY;
		else if (r < 60)
			op = OP_CONT;
		else if (r < 68)
			op = OP_TEXT;
		else if (r < 80)
			op = OP_PING;
		else if (r < 86)
			op = OP_PONG;
		else if (r < 93)
			op = 4'($urandom_range(OP_DATA_MAX, OP_BINARY + 1));
		else
			op = 4'($urandom_range(OP_LAST, OP_PONG + 1));
		bin = binary_next(op);
		fin = ($urandom_range(99) < 70);
		mk = ($urandom_range(99) < 70);
		r = $urandom_range(99);
		if (r < 12)
			len = 0;
		else if (r < 75)
			len = $urandom_range(12, 1);
		else if (r < 95)
			len = $urandom_range(40, 13);
		else
			len = $urandom_range(200, 126);
		// dropped payloads stay short; binary never exceeds the limit here
		if (!bin && len > 24)
			len = $urandom_range(24);
		if (bin && len > sb.limit)
			len = sb.limit;
		if (len >= LEN_CODE_16)
			form = $urandom_range(2, 1);
		else
			form = ($urandom_range(99) < 85) ? 0 : $urandom_range(2, 1);
		send_frame(fin, op, mk, form, 64'(len));
	endtask

	task random_frames(input int unsigned budget);
		int unsigned stop_at;
		stop_at = items_sent + budget;
		while (items_sent < stop_at)
			random_frame();
	endtask

	// stop sending and let every expected event come out
	task wait_all_events();
		@(negedge clk) in_valid <= 1'b0;
		while (sb.due_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_payload_limit(input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.limit = value;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] phase_limit[5];
		logic [63:0] big_len;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'd0;
		cfg_valid = 1'b0;
		cfg_data = 32'd0;
		sb = new;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// continuation before any message: dropped
		send_frame(1'b1, OP_CONT, 1'b0, 0, 1);
		// empty binary fragment, then empty ping
		send_frame(1'b0, OP_BINARY, 1'b0, 0, 0);
		send_frame(1'b1, OP_PING, 1'b0, 0, 0);
		// masked binary fragment with extreme bytes
		send_header(1'b0, OP_BINARY, 1'b1, 0, 2);
		send_byte(8'h00);
		send_byte(8'hFF);
		// ping between fragments keeps the message binary
		send_frame(1'b1, OP_PING, 1'b0, 0, 1);
		// unmasked final continuation passes bytes unchanged
		send_header(1'b1, OP_CONT, 1'b0, 0, 2);
		send_byte(8'hFF);
		send_byte(8'h00);
		// text and pong payloads are dropped
		send_frame(1'b1, OP_TEXT, 1'b0, 0, 1);
		send_frame(1'b1, OP_PONG, 1'b0, 0, 0);

		// no idling; sink holds off while a long binary frame fills the queue
		quiet = 1'b1;
		hold_reqs++;
		send_frame(1'b1, OP_BINARY, 1'b1, 0, 40);
		random_frames(80);
		quiet = 1'b0;
		random_frames(20);

		// limit sweep, each setting written with the block idle
		phase_limit[0] = $urandom();
		phase_limit[1] = 32'd0;
		phase_limit[2] = $urandom_range(8, 1);
		phase_limit[3] = 32'hFFFF_FFFF;
		phase_limit[4] = $urandom_range(300, 100);
		foreach (phase_limit[p]) begin
			wait_all_events();
			write_payload_limit(phase_limit[p]);
			random_frames(90);
		end

		// connection close, by oversize binary or by close opcode
		wait_all_events();
		if ($urandom_range(1)) begin
			write_payload_limit(32'hFFFF_FFFF);
			big_len = {$urandom(), $urandom()};
			big_len[63] = 1'b1;
			send_header(1'b1, OP_BINARY, 1'($urandom_range(1)), 2, big_len);
		end else begin
			send_header(1'b1, OP_CLOSE, 1'($urandom_range(1)), 0, 64'($urandom_range(4)));
		end
		// everything after the close is ignored
		repeat (8) send_byte(8'($urandom_range(255)));
		wait_all_events();

		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
